/* src/gssp_pkg.sv */
`timescale 1ns / 1ps
package gssp_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int RAD_W     = 24;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int MAG_W     = 12;

    // points per sphere are clamped to this
    localparam int MAX_POINTS = 4096;

    // pipeline unit lengths
    localparam int DIV_STEPS    = 31;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 24;

    // back pipeline stage numbers
    localparam int ST_Z      = DIV_STEPS + 1;
    localparam int ST_SQ_END = ST_Z + SQRT_STEPS;
    localparam int ST_CS_IN  = ST_SQ_END - CORDIC_STEPS;
    localparam int ST_U      = ST_SQ_END + 1;
    localparam int ST_P      = ST_U + 1;

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // golden angle as a 32-bit turn fraction
    localparam logic [31:0] GOLDEN_TURN = 32'h61C88647;

    // cordic datapath
    localparam int CS_W = 34;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
    localparam logic signed [CS_W-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    // one classified word from the front end
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RAD_W-1:0]          rad;
        logic [CNT_W-1:0]          n;
        logic [MAG_W-1:0]          mag;
        logic                      neg;
        logic                      valid;
        logic                      last;
        t_quad                     quad;
        logic signed [31:0]        resid;
    } t_item;

    // queue status
    typedef struct packed {
        logic          full;
        logic          empty;
        logic [Q_AW:0] count;
    } t_q_status;

endpackage

/* src/golden_spiral_sphere_point_top.sv */
`timescale 1ns / 1ps
// Golden-spiral sphere point generator. Each input word carries a sphere centre
// (signed Q16.16), a radius (unsigned Q8.16) and a point index k; the block returns
// point k of an N-point golden-section spiral on that sphere, N being the point
// count register (clamped to 4096). A new word is taken every cycle while the queue
// is not full, one result word leaves per cycle while the output is not held, and a
// word passes the 4-entry input queue, a 31-stage pipelined divider for the height,
// a squaring stage, a 31-stage pipelined square root with a 24-stage CORDIC beside
// it, two multiply stages and the output register. A held output freezes the back
// pipeline; the queue keeps taking words until it is full. Indexes at or beyond N
// give point_valid = 0 with zero coordinates; the last index of a sphere sets
// last_point. Write the point count only while the block is idle.
module golden_spiral_sphere_point_top import gssp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CNT_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [RAD_W-1:0]          i_sphere_radius,
    input  logic [IDX_W-1:0]          i_point_index,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_point_x,
    output logic signed [COORD_W-1:0] o_point_y,
    output logic signed [COORD_W-1:0] o_point_z,
    output logic                      o_point_valid,
    output logic                      o_last_point
);

    t_q_status w_q_status;
    t_item     w_in_item;
    t_item     w_q_item;
    logic      w_push;
    logic      w_pop;

    // accept and classify
    gssp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_center_z      (i_center_z),
        .i_sphere_radius (i_sphere_radius),
        .i_point_index   (i_point_index),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_item          (w_in_item)
    );

    // decoupling queue
    gssp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_in_item),
        .i_pop    (w_pop),
        .o_item   (w_q_item),
        .o_status (w_q_status)
    );

    // point arithmetic
    gssp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_point_valid (o_point_valid),
        .o_last_point  (o_last_point)
    );

    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count beyond depth");

    // out-of-range points carry zero coordinates
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_point_valid) |->
        (o_point_x == '0 && o_point_y == '0 && o_point_z == '0))
        else $error("invalid point with nonzero coordinates");

    // last mark only on a valid point
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_point) |-> o_point_valid)
        else $error("last mark on invalid point");

endmodule

/* src/gssp_front.sv */
`timescale 1ns / 1ps
module gssp_front import gssp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CNT_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [RAD_W-1:0]          i_sphere_radius,
    input  logic [IDX_W-1:0]          i_point_index,
    input  t_q_status                 i_q_status,
    output logic                      o_push,
    output t_item                     o_item
);

    logic [CNT_W-1:0] r_point_count;
    logic [CNT_W-1:0] w_n;
    logic [CNT_W:0]   w_num;
    logic [CNT_W:0]   w_abs;
    logic [31:0]      w_turn;
    logic [31:0]      w_qsum;

    // point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    // classify the word: range, height numerator, longitude split
    always_comb begin
        w_n    = (r_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_point_count;
        w_num  = {1'b0, w_n} - {1'b0, i_point_index, 1'b0} - (CNT_W+1)'(1);
        w_abs  = w_num[CNT_W] ? (~w_num + (CNT_W+1)'(1)) : w_num;
        w_turn = {{(32-IDX_W){1'b0}}, i_point_index} * GOLDEN_TURN;
        w_qsum = w_turn + 32'h2000_0000;

        o_item.cx    = i_center_x;
        o_item.cy    = i_center_y;
        o_item.cz    = i_center_z;
        o_item.rad   = i_sphere_radius;
        o_item.n     = w_n;
        o_item.mag   = w_abs[MAG_W-1:0];
        o_item.neg   = w_num[CNT_W];
        o_item.valid = ({1'b0, i_point_index} < w_n);
        o_item.last  = ({1'b0, i_point_index} < w_n) &&
                       ({1'b0, i_point_index} == (w_n - CNT_W'(1)));
        o_item.quad  = t_quad'(w_qsum[31:30]);
        o_item.resid = $signed(w_turn - {w_qsum[31:30], 30'd0});
    end

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

endmodule

/* src/gssp_fifo.sv */
`timescale 1ns / 1ps
module gssp_fifo import gssp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item           r_mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_status.count = r_cnt;

endmodule

/* src/gssp_cordic.sv */
`timescale 1ns / 1ps
module gssp_cordic import gssp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_quad              i_quad,
    input  logic signed [31:0] i_resid,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    logic signed [CS_W-1:0] r_x [0:CORDIC_STEPS-1];
    logic signed [CS_W-1:0] r_y [0:CORDIC_STEPS-1];
    logic signed [CS_W-1:0] r_a [0:CORDIC_STEPS-1];
    t_quad                  r_q [0:CORDIC_STEPS-1];

    logic signed [CS_W-1:0] p_x [0:CORDIC_STEPS-1];
    logic signed [CS_W-1:0] p_y [0:CORDIC_STEPS-1];
    logic signed [CS_W-1:0] p_a [0:CORDIC_STEPS-1];
    t_quad                  p_q [0:CORDIC_STEPS-1];

    logic signed [CS_W-1:0] n_x [0:CORDIC_STEPS-1];
    logic signed [CS_W-1:0] n_y [0:CORDIC_STEPS-1];
    logic signed [CS_W-1:0] n_a [0:CORDIC_STEPS-1];

    logic signed [CS_W-1:0] w_x;
    logic signed [CS_W-1:0] w_y;

    // one rotation per stage
    always_comb begin
        p_x[0] = CORDIC_GAIN;
        p_y[0] = '0;
        p_a[0] = CS_W'(i_resid);
        p_q[0] = i_quad;
        for (int j = 1; j < CORDIC_STEPS; j++) begin
            p_x[j] = r_x[j-1];
            p_y[j] = r_y[j-1];
            p_a[j] = r_a[j-1];
            p_q[j] = r_q[j-1];
        end
        for (int j = 0; j < CORDIC_STEPS; j++) begin
            if (!p_a[j][CS_W-1]) begin
                n_x[j] = p_x[j] - (p_y[j] >>> j);
                n_y[j] = p_y[j] + (p_x[j] >>> j);
                n_a[j] = p_a[j] - ATAN_TURNS[j];
            end else begin
                n_x[j] = p_x[j] + (p_y[j] >>> j);
                n_y[j] = p_y[j] - (p_x[j] >>> j);
                n_a[j] = p_a[j] + ATAN_TURNS[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < CORDIC_STEPS; j++) begin
                r_x[j] <= n_x[j];
                r_y[j] <= n_y[j];
                r_a[j] <= n_a[j];
                r_q[j] <= p_q[j];
            end
        end
    end

    // quarter-turn rotation
    always_comb begin
        case (r_q[CORDIC_STEPS-1])
            QUAD_0: begin
                w_x = r_x[CORDIC_STEPS-1];
                w_y = r_y[CORDIC_STEPS-1];
            end
            QUAD_1: begin
                w_x = -r_y[CORDIC_STEPS-1];
                w_y = r_x[CORDIC_STEPS-1];
            end
            QUAD_2: begin
                w_x = -r_x[CORDIC_STEPS-1];
                w_y = -r_y[CORDIC_STEPS-1];
            end
            default: begin
                w_x = r_y[CORDIC_STEPS-1];
                w_y = -r_x[CORDIC_STEPS-1];
            end
        endcase
    end

    assign o_cos = w_x[31:0];
    assign o_sin = w_y[31:0];

endmodule

/* src/gssp_back.sv */
`timescale 1ns / 1ps
module gssp_back import gssp_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_q_status                 i_q_status,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [COORD_W-1:0] o_point_x,
    output logic signed [COORD_W-1:0] o_point_y,
    output logic signed [COORD_W-1:0] o_point_z,
    output logic                      o_point_valid,
    output logic                      o_last_point
);

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RAD_W-1:0]          rad;
        logic                      valid;
        logic                      last;
        logic                      neg;
        t_quad                     quad;
        logic signed [31:0]        resid;
        logic signed [31:0]        zq;
    } t_side;

    localparam logic [61:0] ONE_SQ = 62'd1 << 60;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [32:0] v);
        logic signed [COORD_W-1:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic  w_en;
    logic  r_vld  [0:ST_P];
    t_side r_side [0:ST_P];

    // divider state
    logic [CNT_W-1:0]     r_dv_rem [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_dv_q   [0:DIV_STEPS];
    logic [CNT_W-1:0]     r_dv_n   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_dv_lo  [0:DIV_STEPS];
    logic [CNT_W-1:0]     n_dv_rem [1:DIV_STEPS];
    logic [DIV_STEPS-1:0] n_dv_q   [1:DIV_STEPS];

    // square root state
    logic [31:0]           r_sq_rem  [0:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_sq_root [0:SQRT_STEPS];
    logic [61:0]           r_sq_v    [0:SQRT_STEPS];
    logic [31:0]           n_sq_rem  [1:SQRT_STEPS];
    logic [SQRT_STEPS-1:0] n_sq_root [1:SQRT_STEPS];

    logic signed [31:0] n_zq;
    logic [61:0]        n_v;
    t_side              w_side_z;

    logic signed [31:0] w_cos;
    logic signed [31:0] w_sin;
    logic signed [63:0] w_cr;
    logic signed [63:0] w_sr;
    logic signed [32:0] r_ux;
    logic signed [32:0] r_uy;
    logic signed [57:0] w_pxp;
    logic signed [57:0] w_pyp;
    logic signed [56:0] w_pzp;
    logic signed [28:0] r_px;
    logic signed [28:0] r_py;
    logic signed [28:0] r_pz;

    logic                      r_o_valid;
    logic signed [COORD_W-1:0] r_o_x;
    logic signed [COORD_W-1:0] r_o_y;
    logic signed [COORD_W-1:0] r_o_z;
    logic                      r_o_pv;
    logic                      r_o_last;

    // whole pipeline moves unless the output word is held
    assign w_en  = !(r_o_valid && i_stall);
    assign o_pop = w_en && !i_q_status.empty;

    // restoring divider steps, one quotient bit each
    always_comb begin
        logic [CNT_W:0] t;
        logic           ge;
        for (int j = 1; j <= DIV_STEPS; j++) begin
            t           = {r_dv_rem[j-1], r_dv_lo[j-1][DIV_STEPS-j]};
            ge          = (t >= {1'b0, r_dv_n[j-1]});
            n_dv_rem[j] = ge ? CNT_W'(t - {1'b0, r_dv_n[j-1]}) : t[CNT_W-1:0];
            n_dv_q[j]   = {r_dv_q[j-1][DIV_STEPS-2:0], ge};
        end
    end

    // signed height and radicand
    always_comb begin
        n_zq = r_side[ST_Z-1].neg ? -$signed({1'b0, r_dv_q[DIV_STEPS]})
                                  :  $signed({1'b0, r_dv_q[DIV_STEPS]});
        n_v  = ONE_SQ - (r_dv_q[DIV_STEPS] * r_dv_q[DIV_STEPS]);
        w_side_z    = r_side[ST_Z-1];
        w_side_z.zq = n_zq;
    end

    // square root steps, one root bit each
    always_comb begin
        logic [33:0] t;
        logic [33:0] trial;
        logic        ge;
        for (int j = 1; j <= SQRT_STEPS; j++) begin
            t            = {r_sq_rem[j-1], r_sq_v[j-1][61:60]};
            trial        = {1'b0, r_sq_root[j-1], 2'b01};
            ge           = (t >= trial);
            n_sq_rem[j]  = ge ? 32'(t - trial) : t[31:0];
            n_sq_root[j] = {r_sq_root[j-1][SQRT_STEPS-2:0], ge};
        end
    end

    gssp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_quad  (r_side[ST_CS_IN].quad),
        .i_resid (r_side[ST_CS_IN].resid),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // unit vector and radius products
    assign w_cr  = w_cos * $signed({1'b0, r_sq_root[SQRT_STEPS]});
    assign w_sr  = w_sin * $signed({1'b0, r_sq_root[SQRT_STEPS]});
    assign w_pxp = r_ux * $signed({1'b0, r_side[ST_U].rad});
    assign w_pyp = r_uy * $signed({1'b0, r_side[ST_U].rad});
    assign w_pzp = r_side[ST_U].zq * $signed({1'b0, r_side[ST_U].rad});

    // control: stage valids and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ST_P; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= o_pop;
            for (int s = 1; s <= ST_P; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_o_valid <= r_vld[ST_P];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // load from the queue head
            r_side[0].cx    <= i_item.cx;
            r_side[0].cy    <= i_item.cy;
            r_side[0].cz    <= i_item.cz;
            r_side[0].rad   <= i_item.rad;
            r_side[0].valid <= i_item.valid;
            r_side[0].last  <= i_item.last;
            r_side[0].neg   <= i_item.neg;
            r_side[0].quad  <= i_item.quad;
            r_side[0].resid <= i_item.resid;
            r_side[0].zq    <= '0;
            r_dv_rem[0]     <= CNT_W'(i_item.mag[MAG_W-1:1]);
            r_dv_q[0]       <= '0;
            r_dv_n[0]       <= i_item.n;
            r_dv_lo[0]      <= {i_item.mag[0], {(DIV_STEPS-CNT_W){1'b0}},
                                i_item.n[CNT_W-1:1]};

            // the height stage picks up the signed quotient
            for (int s = 1; s <= ST_P; s++) begin
                r_side[s] <= (s == ST_Z) ? w_side_z : r_side[s-1];
            end

            for (int j = 1; j <= DIV_STEPS; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_q[j]   <= n_dv_q[j];
                r_dv_n[j]   <= r_dv_n[j-1];
                r_dv_lo[j]  <= r_dv_lo[j-1];
            end

            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_v[0]    <= n_v;
            for (int j = 1; j <= SQRT_STEPS; j++) begin
                r_sq_rem[j]  <= n_sq_rem[j];
                r_sq_root[j] <= n_sq_root[j];
                r_sq_v[j]    <= r_sq_v[j-1] << 2;
            end

            r_ux <= 33'((w_cr + 64'sd536870912) >>> 30);
            r_uy <= 33'((w_sr + 64'sd536870912) >>> 30);

            r_px <= 29'((w_pxp + 58'sd536870912) >>> 30);
            r_py <= 29'((w_pyp + 58'sd536870912) >>> 30);
            r_pz <= 29'((w_pzp + 57'sd536870912) >>> 30);

            // centre offset, saturation, out-of-range points read zero
            if (r_side[ST_P].valid) begin
                r_o_x <= sat32(33'(r_side[ST_P].cx) + 33'(r_px));
                r_o_y <= sat32(33'(r_side[ST_P].cy) + 33'(r_py));
                r_o_z <= sat32(33'(r_side[ST_P].cz) + 33'(r_pz));
            end else begin
                r_o_x <= '0;
                r_o_y <= '0;
                r_o_z <= '0;
            end
            r_o_pv   <= r_side[ST_P].valid;
            r_o_last <= r_side[ST_P].last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_point_x     = r_o_x;
    assign o_point_y     = r_o_y;
    assign o_point_z     = r_o_z;
    assign o_point_valid = r_o_pv;
    assign o_last_point  = r_o_last;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import gssp_pkg::*;

    localparam int      CYCLE_LIMIT = 1000000;
    localparam int      DRAIN_WAIT  = 100;
    localparam longint  UNIT_HALF   = 64'sd536870912;
    localparam longint  UNIT_ONE_SQ = 64'sd1152921504606846976;

    typedef struct {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [RAD_W-1:0]          rad;
        logic [IDX_W-1:0]          idx;
    } t_sphere_req;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      pv;
        logic                      lp;
    } t_surface_pt;

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      i_cfg_we = 0;
    logic [CNT_W-1:0]          i_cfg_data = '0;
    logic                      i_valid = 0;
    logic                      o_stall;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic signed [COORD_W-1:0] i_center_z = '0;
    logic [RAD_W-1:0]          i_sphere_radius = '0;
    logic [IDX_W-1:0]          i_point_index = '0;
    logic                      o_valid;
    logic                      i_stall = 0;
    logic signed [COORD_W-1:0] o_point_x;
    logic signed [COORD_W-1:0] o_point_y;
    logic signed [COORD_W-1:0] o_point_z;
    logic                      o_point_valid;
    logic                      o_last_point;

    t_sphere_req      req_pending[$];
    t_surface_pt      pt_expected[$];
    logic [CNT_W-1:0] point_count = '0;
    bit               no_idle = 0;
    int               err_count = 0;
    int               cycles = 0;
    int               send_gap = 0;
    int               stall_hold = 0;

    golden_spiral_sphere_point_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_center_x(i_center_x), .i_center_y(i_center_y), .i_center_z(i_center_z),
        .i_sphere_radius(i_sphere_radius), .i_point_index(i_point_index),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_point_x(o_point_x), .o_point_y(o_point_y), .o_point_z(o_point_z),
        .o_point_valid(o_point_valid), .o_last_point(o_last_point)
    );

    // clock
    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // q30 round to nearest, ties up
    function automatic longint round_q30(longint v);
        return (v + UNIT_HALF) >>> 30;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // append a request to the pending list
    function automatic void add_req(t_sphere_req w);
        req_pending.insert(req_pending.size(), w);
    endfunction

    // expected surface point for one request
    function automatic t_surface_pt spiral_point(t_sphere_req w, logic [CNT_W-1:0] cnt);
        t_surface_pt       res;
        longint            n, k, num, mag, zq, root, c, s, ux, uy, ang, cx, cy, dx, dy;
        longint unsigned   rem, acc, bitv;
        logic [31:0]       turn;
        logic [1:0]        q;
        int                resid;
        res = '{x: '0, y: '0, z: '0, pv: 1'b0, lp: 1'b0};
        n = (cnt > CNT_W'(MAX_POINTS)) ? longint'(MAX_POINTS) : longint'(cnt);
        k = longint'(w.idx);
        if (k >= n) return res;
        // height, rounded half away from zero
        num = n - 2 * k - 1;
        mag = (num < 0) ? -num : num;
        mag = ((mag <<< 30) + (n / 2)) / n;
        zq  = (num < 0) ? -mag : mag;
        // spiral radius by bitwise integer root
        rem  = UNIT_ONE_SQ - zq * zq;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= acc + bitv) begin
                rem = rem - (acc + bitv);
                acc = (acc >> 1) + bitv;
            end else begin
                acc = acc >> 1;
            end
            bitv = bitv >> 2;
        end
        root = acc;
        // longitude: quadrant plus cordic residue
        turn  = w.idx * GOLDEN_TURN;
        q     = 2'((turn + 32'h20000000) >> 30);
        resid = turn - ({30'd0, q} << 30);
        ang   = longint'(resid);
        cx    = longint'(CORDIC_GAIN);
        cy    = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ang >= 0) begin
                cx -= dx; cy += dy; ang -= longint'(ATAN_TURNS[i]);
            end else begin
                cx += dx; cy -= dy; ang += longint'(ATAN_TURNS[i]);
            end
        end
        case (t_quad'(q))
            QUAD_0: begin c = cx;  s = cy;  end
            QUAD_1: begin c = -cy; s = cx;  end
            QUAD_2: begin c = -cx; s = -cy; end
            default: begin c = cy; s = -cx; end
        endcase
        ux = round_q30(c * root);
        uy = round_q30(s * root);
        res.x  = clamp_coord(longint'(w.cx) + round_q30(ux * longint'(w.rad)));
        res.y  = clamp_coord(longint'(w.cy) + round_q30(uy * longint'(w.rad)));
        res.z  = clamp_coord(longint'(w.cz) + round_q30(zq * longint'(w.rad)));
        res.pv = 1'b1;
        res.lp = (k == n - 1);
        return res;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_center();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_sphere_req random_req(logic [CNT_W-1:0] cnt);
        t_sphere_req w;
        int          n;
        n    = (cnt > CNT_W'(MAX_POINTS)) ? MAX_POINTS : int'(cnt);
        w.cx = pick_center();
        w.cy = pick_center();
        w.cz = pick_center();
        case ($urandom_range(0, 9))
            0: w.rad = '1;
            1: w.rad = '0;
            2: w.rad = RAD_W'($urandom_range(0, 24'h03FFFF));
            default: w.rad = RAD_W'($urandom);
        endcase
        // mostly indexes within the sphere
        if (n > 0 && $urandom_range(0, 9) < 8) w.idx = IDX_W'($urandom_range(0, n - 1));
        else w.idx = IDX_W'($urandom_range(0, 4095));
        return w;
    endfunction

    function automatic t_sphere_req make_req(int cx, int cy, int cz, int rad, int idx);
        t_sphere_req w;
        w.cx = cx; w.cy = cy; w.cz = cz; w.rad = RAD_W'(rad); w.idx = IDX_W'(idx);
        return w;
    endfunction

    // driver: record accepted word, then present the next one
    always @(posedge i_clk) begin
        logic        nxt_valid;
        t_sphere_req w;
        if (i_rst_n) begin
            nxt_valid = i_valid;
            if (i_valid && !o_stall) begin
                w.cx = i_center_x; w.cy = i_center_y; w.cz = i_center_z;
                w.rad = i_sphere_radius; w.idx = i_point_index;
                pt_expected.insert(pt_expected.size(), spiral_point(w, point_count));
                nxt_valid = 0;
                send_gap  = idle_len();
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_pending.size() > 0) begin
                    w = req_pending.pop_front();
                    i_center_x      <= w.cx;
                    i_center_y      <= w.cy;
                    i_center_z      <= w.cz;
                    i_sphere_radius <= w.rad;
                    i_point_index   <= w.idx;
                    nxt_valid = 1;
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // monitor: random backpressure and compare each word
    always @(posedge i_clk) begin
        t_surface_pt e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pt_expected.size() == 0) begin
                    $display("%0t: unexpected word x=%h y=%h z=%h", $time,
                             o_point_x, o_point_y, o_point_z);
                    err_count++;
                end else begin
                    e = pt_expected.pop_front();
                    if (o_point_x !== e.x) begin
                        $display("%0t: point_x exp %h got %h", $time, e.x, o_point_x);
                        err_count++;
                    end
                    if (o_point_y !== e.y) begin
                        $display("%0t: point_y exp %h got %h", $time, e.y, o_point_y);
                        err_count++;
                    end
                    if (o_point_z !== e.z) begin
                        $display("%0t: point_z exp %h got %h", $time, e.z, o_point_z);
                        err_count++;
                    end
                    if (o_point_valid !== e.pv) begin
                        $display("%0t: point_valid exp %b got %b", $time, e.pv, o_point_valid);
                        err_count++;
                    end
                    if (o_last_point !== e.lp) begin
                        $display("%0t: last_point exp %b got %b", $time, e.lp, o_last_point);
                        err_count++;
                    end
                end
            end
            if (stall_hold > 0) begin
                stall_hold--;
            end else if (i_stall) begin
                i_stall    <= 0;
                stall_hold = idle_len();
            end else begin
                i_stall    <= (idle_len() > 0);
                stall_hold = $urandom_range(0, 6);
            end
        end
    end

    // phases: write the count while idle, then stream words
    initial begin
        logic [CNT_W-1:0] counts [10];
        counts = '{13'd4096, 13'd0, 13'd1, 13'd2, 13'd8191, 13'd4095, 13'd0, 13'd0,
                   13'd37, 13'd4096};
        counts[6] = CNT_W'($urandom_range(1, 4096));
        counts[7] = CNT_W'($urandom_range(0, 8191));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        for (int p = 0; p < 10; p++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1;
            i_cfg_data <= counts[p];
            @(posedge i_clk);
            i_cfg_we   <= 0;
            point_count = counts[p];
            no_idle     = (p % 3 == 1);
            if (p == 0) begin
                // poles, equator, last index, saturation and zero radius
                add_req(make_req(0, 0, 0, 24'h010000, 0));
                add_req(make_req(0, 0, 0, 24'h010000, 4095));
                add_req(make_req(0, 0, 0, 24'h010000, 2048));
                add_req(make_req(0, 0, 0, 24'h010000, 1));
                add_req(make_req(0, 0, 0, 24'h010000, 1024));
                add_req(make_req(0, 0, 0, 24'h010000, 3072));
                add_req(make_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                 24'hFFFFFF, 0));
                add_req(make_req(32'h80000000, 32'h80000000, 32'h80000000,
                                 24'hFFFFFF, 4095));
                add_req(make_req(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                 24'hFFFFFF, 2047));
                add_req(make_req(32'h12345678, -5, 7, 0, 777));
                add_req(make_req(0, 0, 0, 24'hFFFFFF, 5));
            end
            if (p == 1 || p == 2) begin
                // empty sphere and single point sphere
                add_req(make_req(1, 2, 3, 24'h020000, 0));
                add_req(make_req(1, 2, 3, 24'h020000, 1));
                add_req(make_req(1, 2, 3, 24'h020000, 4095));
            end
            for (int i = 0; i < 170; i++) add_req(random_req(counts[p]));
            wait (req_pending.size() == 0 && !i_valid && pt_expected.size() == 0);
            repeat (DRAIN_WAIT) @(posedge i_clk);
        end
        if (err_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
src/gssp_pkg.sv
src/gssp_front.sv
src/gssp_fifo.sv
src/gssp_cordic.sv
src/gssp_back.sv
src/golden_spiral_sphere_point_top.sv
tb/sv/testbench.sv
